@@ rtl/pafs_pkg.sv @@
// Package for the page allocator: sizes, command codes, beat structs and FSM states.
// Used by page_allocator_free_stack_bitmap_unit; depends on nothing.

package pafs_pkg;

    // Page space and reserved pages at the bottom of it
    localparam int MAX_PAGES      = 1024;
    localparam int RESERVED_PAGES = 3;

    // Widths: page address, counters that can hold MAX_PAGES, beat fields
    localparam int PAGE_W  = $clog2(MAX_PAGES);
    localparam int COUNT_W = $clog2(MAX_PAGES + 1);
    localparam int FIELD_W = 10;
    localparam int RSV_W   = (RESERVED_PAGES > 1) ? $clog2(RESERVED_PAGES) : 1;

    // Command codes
    typedef enum logic [1:0] {
        KIND_ALLOC  = 2'd0,
        KIND_FREE   = 2'd1,
        KIND_LOCK   = 2'd2,
        KIND_UNLOCK = 2'd3
    } kind_t;

    // Request beat
    typedef struct packed {
        kind_t              kind;
        logic [FIELD_W-1:0] page_index;
    } req_t;

    // Response beat
    typedef struct packed {
        logic               ok;
        logic [FIELD_W-1:0] granted_page;
    } resp_t;

    // Per-page flags as held in the flag memory
    typedef struct packed {
        logic used;
        logic locked;
    } page_flags_t;

    // Sequencer states
    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } state_t;

endpackage

@@ rtl/pafs_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.

module pafs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/page_allocator_free_stack_bitmap_unit.sv @@
// Top level of the page allocator: command sequencer, flag memory and free-page stack.
// Depends on pafs_pkg and pafs_ram.
//
//  channel    ports                 handshake
//  ---------  --------------------  -----------------------------------------------
//  command    start, busy, request  beat taken at an edge with start high, busy low
//  result     done, response        one beat per command, done high for one cycle
//
// The edge that takes a command issues the reads of the flag memory and of the stack
// top; the next edge writes the memories that the command needs and registers the
// result, shown in the following cycle while the next command may already be taken.
// This split follows from the flag memory's registered read.
// Reset is immediate: stack depth and reserved-page lock bits clear, the high-water
// count starts at three, no memory sweep; pages at or above the high-water count
// read as unused and unlocked.
// The receiver cannot stall: busy only covers the execute state of each command.

module page_allocator_free_stack_bitmap_unit (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  pafs_pkg::req_t  request,
    output logic            done,
    output pafs_pkg::resp_t response
);

    pafs_pkg::state_t state_reg, state_next;
    pafs_pkg::req_t   req_reg;

    logic [pafs_pkg::COUNT_W-1:0] hwc_reg, hwc_next;
    logic [pafs_pkg::COUNT_W-1:0] depth_reg, depth_next;
    logic [pafs_pkg::RESERVED_PAGES-1:0] rsv_lock_reg, rsv_lock_next;

    logic            done_reg, done_next;
    pafs_pkg::resp_t resp_reg, resp_next;

    // Memory ports
    logic                        flag_re, flag_we;
    logic [pafs_pkg::PAGE_W-1:0] flag_raddr, flag_waddr;
    pafs_pkg::page_flags_t       flag_rdata, flag_wdata;
    logic                        stk_re, stk_we;
    logic [pafs_pkg::PAGE_W-1:0] stk_raddr, stk_waddr;
    logic [pafs_pkg::PAGE_W-1:0] stk_rdata, stk_wdata;

    // Decode of the held command
    logic [pafs_pkg::COUNT_W-1:0] page_ext;
    logic                         is_reserved;
    logic [pafs_pkg::RSV_W-1:0]   rsv_idx;
    pafs_pkg::page_flags_t        flags_eff;
    logic                         accept;

    assign accept      = start && (state_reg == pafs_pkg::ST_IDLE);
    assign page_ext    = pafs_pkg::COUNT_W'(req_reg.page_index);
    assign is_reserved = page_ext < pafs_pkg::COUNT_W'(pafs_pkg::RESERVED_PAGES);
    assign rsv_idx     = req_reg.page_index[pafs_pkg::RSV_W-1:0];

    pafs_ram #(
        .WIDTH ($bits(pafs_pkg::page_flags_t)),
        .DEPTH (pafs_pkg::MAX_PAGES)
    ) u_flag_ram (
        .clk   (clk),
        .we    (flag_we),
        .waddr (flag_waddr),
        .wdata (flag_wdata),
        .re    (flag_re),
        .raddr (flag_raddr),
        .rdata (flag_rdata)
    );

    pafs_ram #(
        .WIDTH (pafs_pkg::PAGE_W),
        .DEPTH (pafs_pkg::MAX_PAGES)
    ) u_stack_ram (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .re    (stk_re),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pafs_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = pafs_pkg::ST_EXEC;
                end
            end
            pafs_pkg::ST_EXEC:
            begin
                state_next = pafs_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = pafs_pkg::ST_IDLE;
            end
        endcase
    end

    // State outputs: busy, read issue, result strobe
    always_comb
    begin
        busy       = 1'b0;
        flag_re    = 1'b0;
        stk_re     = 1'b0;
        done_next  = 1'b0;
        flag_raddr = pafs_pkg::PAGE_W'(request.page_index);
        stk_raddr  = pafs_pkg::PAGE_W'(depth_reg - pafs_pkg::COUNT_W'(1));
        case (state_reg)
            pafs_pkg::ST_IDLE:
            begin
                flag_re = start;
                stk_re  = start;
            end
            pafs_pkg::ST_EXEC:
            begin
                busy      = 1'b1;
                done_next = 1'b1;
            end
            default:
            begin
                busy = 1'b0;
            end
        endcase
    end

    // Effective flags: reserved pages from flip-flops, untouched pages clear
    always_comb
    begin
        if (is_reserved)
        begin
            flags_eff.used   = 1'b1;
            flags_eff.locked = rsv_lock_reg[rsv_idx];
        end
        else if (page_ext >= hwc_reg)
        begin
            flags_eff = '0;
        end
        else
        begin
            flags_eff = flag_rdata;
        end
    end

    // Execute: decide, build writes and the result
    always_comb
    begin
        hwc_next      = hwc_reg;
        depth_next    = depth_reg;
        rsv_lock_next = rsv_lock_reg;
        resp_next     = '0;
        flag_we       = 1'b0;
        flag_waddr    = pafs_pkg::PAGE_W'(req_reg.page_index);
        flag_wdata    = '0;
        stk_we        = 1'b0;
        stk_waddr     = depth_reg[pafs_pkg::PAGE_W-1:0];
        stk_wdata     = pafs_pkg::PAGE_W'(req_reg.page_index);
        if (state_reg == pafs_pkg::ST_EXEC)
        begin
            case (req_reg.kind)
                pafs_pkg::KIND_ALLOC:
                begin
                    flag_wdata.used   = 1'b1;
                    flag_wdata.locked = 1'b0;
                    if (depth_reg != '0)
                    begin
                        // Pop the most recently freed page
                        depth_next             = depth_reg - pafs_pkg::COUNT_W'(1);
                        flag_we                = 1'b1;
                        flag_waddr             = stk_rdata;
                        resp_next.ok           = 1'b1;
                        resp_next.granted_page = pafs_pkg::FIELD_W'(stk_rdata);
                    end
                    else if (hwc_reg < pafs_pkg::COUNT_W'(pafs_pkg::MAX_PAGES))
                    begin
                        // Take a fresh page at the high-water mark
                        hwc_next               = hwc_reg + pafs_pkg::COUNT_W'(1);
                        flag_we                = 1'b1;
                        flag_waddr             = hwc_reg[pafs_pkg::PAGE_W-1:0];
                        resp_next.ok           = 1'b1;
                        resp_next.granted_page = pafs_pkg::FIELD_W'(
                            hwc_reg[pafs_pkg::PAGE_W-1:0]);
                    end
                end
                pafs_pkg::KIND_FREE:
                begin
                    if (!is_reserved && flags_eff.used && !flags_eff.locked &&
                        depth_reg < pafs_pkg::COUNT_W'(pafs_pkg::MAX_PAGES))
                    begin
                        // Push the page and clear its flags
                        stk_we       = 1'b1;
                        depth_next   = depth_reg + pafs_pkg::COUNT_W'(1);
                        flag_we      = 1'b1;
                        resp_next.ok = 1'b1;
                    end
                end
                pafs_pkg::KIND_LOCK:
                begin
                    if (page_ext < hwc_reg && flags_eff.used && !flags_eff.locked)
                    begin
                        resp_next.ok      = 1'b1;
                        flag_wdata.used   = 1'b1;
                        flag_wdata.locked = 1'b1;
                        if (is_reserved)
                        begin
                            rsv_lock_next[rsv_idx] = 1'b1;
                        end
                        else
                        begin
                            flag_we = 1'b1;
                        end
                    end
                end
                pafs_pkg::KIND_UNLOCK:
                begin
                    if (flags_eff.locked)
                    begin
                        resp_next.ok      = 1'b1;
                        flag_wdata.used   = flags_eff.used;
                        flag_wdata.locked = 1'b0;
                        if (is_reserved)
                        begin
                            rsv_lock_next[rsv_idx] = 1'b0;
                        end
                        else
                        begin
                            flag_we = 1'b1;
                        end
                    end
                end
                default:
                begin
                    resp_next = '0;
                end
            endcase
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= pafs_pkg::ST_IDLE;
            hwc_reg      <= pafs_pkg::COUNT_W'(pafs_pkg::RESERVED_PAGES);
            depth_reg    <= '0;
            rsv_lock_reg <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            hwc_reg      <= hwc_next;
            depth_reg    <= depth_next;
            rsv_lock_reg <= rsv_lock_next;
            done_reg     <= done_next;
        end
    end

    // Payload registers: hold the command, latch the result
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= request;
        end
        if (done_next)
        begin
            resp_reg <= resp_next;
        end
    end

    assign done     = done_reg;
    assign response = resp_reg;

    // Every command finishes within its execute state; busy never stays high past it
    a_busy_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> !busy)
        else $error("busy held longer than one cycle");

    // A result beat only follows an execute cycle
    a_done_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == pafs_pkg::ST_EXEC))
        else $error("result strobe without execute cycle");

    // Freed pages never outnumber pages handed out from the high-water mark
    a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (depth_reg + pafs_pkg::COUNT_W'(pafs_pkg::RESERVED_PAGES)) <= hwc_reg)
        else $error("free stack deeper than allocated pages");

    // High-water count stays within the page space
    a_hwc_range: assert property (@(posedge clk) disable iff (!rst_n)
        hwc_reg <= pafs_pkg::COUNT_W'(pafs_pkg::MAX_PAGES))
        else $error("high-water count beyond page space");

    // A refused command grants no page
    a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !response.ok) |-> (response.granted_page == '0))
        else $error("refused command carries a page");

endmodule
